// ----- src/mfd_pkg.sv -----
// Package for the minifloat to binary32 decoder.
// Holds value class codes, binary32 constants and the result type; no dependencies.
`default_nettype none
package mfd_pkg;

  typedef enum logic [1:0] {
    CLS_FINITE  = 2'd0,
    CLS_POS_INF = 2'd1,
    CLS_NEG_INF = 2'd2,
    CLS_NAN     = 2'd3
  } value_class_e;

  localparam logic [31:0] F32_SIGN     = 32'h8000_0000;
  localparam logic [31:0] F32_INF      = 32'h7F80_0000;
  localparam int          F32_MANT     = 23;
  localparam int          F32_BIAS     = 127;
  localparam logic [3:0]  FRAC_LOW     = 4'd2;
  localparam logic [2:0]  EXP_LOW      = 3'd3;
  localparam logic [3:0]  REG_FRAC     = 4'd0;
  localparam logic [3:0]  REG_EXP      = 4'd1;

  typedef struct packed {
    logic         compatible;
    value_class_e value_class;
    logic         sign_out;
    logic [31:0]  binary32_bits;
  } result_t;

endpackage
`default_nettype wire

// ----- src/mfd_cfg.sv -----
// Configuration registers of the decoder with saturation to the legal ranges.
// Depends on mfd_pkg.
`default_nettype none
module mfd_cfg
  import mfd_pkg::*;
#(
  parameter int MAX_FRAC_BITS = 10,
  parameter int MAX_EXP_BITS  = 5
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  output logic [4:0]      frac_width_o,
  output logic [2:0]      exp_width_o
);
  localparam logic [4:0] FRAC_HI = 5'(MAX_FRAC_BITS);
  localparam logic [2:0] EXP_HI  = 3'(MAX_EXP_BITS);

  logic [4:0] frac_q, frac_d, frac_w;
  logic [2:0] exp_q, exp_d, exp_w;

  // Saturate written values
  always_comb begin
    frac_w = {1'b0, cfg_data_i};
    if (frac_w < {1'b0, FRAC_LOW}) frac_w = {1'b0, FRAC_LOW};
    if (frac_w > FRAC_HI) frac_w = FRAC_HI;
    exp_w = cfg_data_i[2:0];
    if (exp_w < EXP_LOW) exp_w = EXP_LOW;
    if (exp_w > EXP_HI) exp_w = EXP_HI;
    frac_d = frac_q;
    exp_d  = exp_q;
    if (cfg_we_i && cfg_idx_i == REG_FRAC) frac_d = frac_w;
    if (cfg_we_i && cfg_idx_i == REG_EXP)  exp_d  = exp_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= (FRAC_HI < 5'd10) ? FRAC_HI : 5'd10;
      exp_q  <= (EXP_HI < 3'd5) ? EXP_HI : 3'd5;
    end else begin
      frac_q <= frac_d;
      exp_q  <= exp_d;
    end
  end

  assign frac_width_o = frac_q;
  assign exp_width_o  = exp_q;
endmodule
`default_nettype wire

// ----- src/mfd_core.sv -----
// Combinational decode of one code word into class, sign and binary32 pattern.
// Depends on mfd_pkg.
`default_nettype none
module mfd_core
  import mfd_pkg::*;
#(
  parameter int MAX_FRAC_BITS = 10,
  parameter int MAX_EXP_BITS  = 5
) (
  input  wire logic [31:0] code_i,
  input  wire logic [4:0]  frac_width_i,
  input  wire logic [2:0]  exp_width_i,
  output result_t          res_o
);
  localparam int FW = MAX_FRAC_BITS;
  localparam int EW = MAX_EXP_BITS;

  logic [5:0]    top;
  logic [31:0]   shr_frac, shr_ex;
  logic [FW-1:0] frac;
  logic [EW-1:0] ex, exp_max;
  logic          sign;
  logic [4:0]    p;
  logic [9:0]    e;
  logic [31:0]   bits;
  logic [63:0]   wide;

  always_comb begin
    top      = 6'(frac_width_i) + 6'(exp_width_i) + 6'd1;
    shr_frac = code_i & ((32'd1 << frac_width_i) - 32'd1);
    frac     = shr_frac[FW-1:0];
    shr_ex   = (code_i >> frac_width_i) & ((32'd1 << exp_width_i) - 32'd1);
    ex       = shr_ex[EW-1:0];
    sign     = code_i[5'(frac_width_i) + 5'(exp_width_i)];
    exp_max  = EW'((32'd1 << exp_width_i) - 32'd1);
    // Leading-one search over the fraction
    p = '0;
    for (int i = 0; i < FW; i++) if (frac[i]) p = 5'(i);
    bits = sign ? F32_SIGN : 32'd0;
    res_o.value_class = CLS_FINITE;
    e = '0;
    wide = '0;
    if (ex == exp_max) begin
      bits = bits | F32_INF;
      if (frac == '0) begin
        res_o.value_class = sign ? CLS_NEG_INF : CLS_POS_INF;
      end else begin
        res_o.value_class = CLS_NAN;
        wide = 64'(frac) << (5'(F32_MANT) - frac_width_i);
        bits = bits | wide[31:0];
      end
    end else if (ex == '0) begin
      if (frac != '0) begin
        e = 10'(p) + 10'd1 - 10'((32'd1 << (exp_width_i - 3'd1)) - 32'd1)
            - 10'(frac_width_i) + 10'(F32_BIAS);
        wide = 64'(frac) << (5'(F32_MANT) - p);
        bits = bits | {1'b0, e[7:0], wide[22:0]};
      end
    end else begin
      e = 10'(ex) - 10'((32'd1 << (exp_width_i - 3'd1)) - 32'd1) + 10'(F32_BIAS);
      wide = 64'(frac) << (5'(F32_MANT) - frac_width_i);
      bits = bits | {1'b0, e[7:0], wide[22:0]};
    end
    res_o.compatible    = (top > 6'd31) ? 1'b1 : ((code_i >> top) == 32'd0);
    res_o.sign_out      = sign;
    res_o.binary32_bits = bits;
    if (!res_o.compatible) begin
      res_o.value_class   = CLS_FINITE;
      res_o.sign_out      = 1'b0;
      res_o.binary32_bits = '0;
    end
  end
endmodule
`default_nettype wire

// ----- src/minifloat_decode_to_binary32.sv -----
// Top level of the minifloat to binary32 decoder: input register, decode, output register.
// Depends on mfd_pkg, mfd_cfg and mfd_core.
//
// Usage:
//   s_axis carries one 32-bit code word per transfer; m_axis returns one result
//   per code word: tuser = {value_class, compatible} packed from bit 0 (3 bits,
//   zero filled to 8), tdata = {binary32_bits, sign_out} packed from bit 0
//   (33 bits, zero filled to 40).
//   A result is valid once its code word has passed the input register and the
//   result register; one code word is taken every cycle while the receiver does
//   not stall, set by the single decode stage between the two registers.
//   When the receiver stalls, the result register holds and the input register
//   keeps its item; s_axis_tready drops only when both are full.
//   Reset empties both stages and loads a 10-bit fraction and a 5-bit exponent
//   (saturated to the parameter limits). Configuration is written by the user through
//   cfg_we_i, cfg_idx_i, cfg_data_i only while the block is idle; the block has no check.
`default_nettype none
module minifloat_decode_to_binary32
  import mfd_pkg::*;
#(
  parameter int MAX_FRAC_BITS = 10,
  parameter int MAX_EXP_BITS  = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // code_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // sign_out, binary32_bits
  output logic [7:0]       m_axis_tuser    // compatible, value_class
);
  logic [4:0]  frac_width;
  logic [2:0]  exp_width;
  logic [31:0] in_q;
  logic        in_vld_q, out_vld_q;
  result_t     res, out_q;
  logic        out_ready, in_ready;

  mfd_cfg #(.MAX_FRAC_BITS(MAX_FRAC_BITS), .MAX_EXP_BITS(MAX_EXP_BITS)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .frac_width_o(frac_width), .exp_width_o(exp_width)
  );

  mfd_core #(.MAX_FRAC_BITS(MAX_FRAC_BITS), .MAX_EXP_BITS(MAX_EXP_BITS)) u_core (
    .code_i(in_q), .frac_width_i(frac_width), .exp_width_i(exp_width), .res_o(res)
  );

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;

  // Advance the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) in_vld_q <= s_axis_tvalid;
      if (out_ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) in_q <= s_axis_tdata;
    if (out_ready && in_vld_q) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.binary32_bits, out_q.sign_out};
  assign m_axis_tuser  = {5'd0, out_q.value_class, out_q.compatible};

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed under stall");
  a_incompat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tuser[2:1] == 2'd0 && m_axis_tdata[32:0] == 33'd0)
    else $error("incompatible result not cleared");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q)
    else $error("stalled while not full");
`endif
endmodule
`default_nettype wire

// ----- dv/minifloat_decode_to_binary32_checker.sv -----
// Result checker for the minifloat to binary32 decoder: predicts each result from
// accepted code words and the current format, compares against m_axis. Uses mfd_pkg.
`default_nettype none
module minifloat_decode_to_binary32_checker
  import mfd_pkg::*;
#(
  parameter int MAX_FRAC_BITS = 10,
  parameter int MAX_EXP_BITS  = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic [7:0]  m_axis_tuser,
  output int               fail_count_o,
  output int               pending_o
);

  int unsigned fmt_frac;
  int unsigned fmt_exp;
  result_t     decoded_q[$];
  int          mismatch_count;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Decode one code word under the current format
  function automatic result_t decode_code(logic [31:0] code);
    result_t     r;
    int unsigned n, k, bias, emax, ex, lead;
    logic [31:0] frac;
    logic        sgn;
    int          e;
    n = fmt_frac;
    k = fmt_exp;
    r = '0;
    if ((code >> (n + k + 1)) != 0) return r;
    frac = code & ((32'd1 << n) - 1);
    ex   = (code >> n) & ((1 << k) - 1);
    sgn  = code[n + k];
    bias = (1 << (k - 1)) - 1;
    emax = (1 << k) - 1;
    r.compatible    = 1'b1;
    r.sign_out      = sgn;
    r.value_class   = CLS_FINITE;
    r.binary32_bits = sgn ? F32_SIGN : 32'd0;
    if (ex == emax) begin
      r.binary32_bits |= F32_INF;
      if (frac == 0) begin
        r.value_class = sgn ? CLS_NEG_INF : CLS_POS_INF;
      end else begin
        r.value_class = CLS_NAN;
        r.binary32_bits |= frac << (F32_MANT - n);
      end
    end else if (ex == 0) begin
      if (frac != 0) begin
        lead = 0;
        for (int i = 0; i < 32; i++) if (frac[i]) lead = i;
        e = lead + 1 - int'(bias) - int'(n) + F32_BIAS;
        r.binary32_bits |= (32'(e) << F32_MANT) | ((frac << (F32_MANT - lead)) & 32'h007F_FFFF);
      end
    end else begin
      e = int'(ex) - int'(bias) + F32_BIAS;
      r.binary32_bits |= (32'(e) << F32_MANT) | (frac << (F32_MANT - n));
    end
    return r;
  endfunction

  assign fail_count_o = mismatch_count;

  // Track format, queue predictions, compare results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      fmt_frac       <= sat(10, FRAC_LOW, MAX_FRAC_BITS);
      fmt_exp        <= sat(5, EXP_LOW, MAX_EXP_BITS);
      mismatch_count <= 0;
      pending_o      <= 0;
      decoded_q.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_FRAC) fmt_frac <= sat(cfg_data_i, FRAC_LOW, MAX_FRAC_BITS);
      if (cfg_we_i && cfg_idx_i == REG_EXP)
        fmt_exp <= sat(cfg_data_i[2:0], EXP_LOW, MAX_EXP_BITS);
      if (s_axis_tvalid && s_axis_tready) decoded_q.push_back(decode_code(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.compatible    = m_axis_tuser[0];
        got.value_class   = value_class_e'(m_axis_tuser[2:1]);
        got.sign_out      = m_axis_tdata[0];
        got.binary32_bits = m_axis_tdata[32:1];
        if (decoded_q.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %h", got);
        end else begin
          want = decoded_q.pop_front();
          if (got.compatible !== want.compatible || got.value_class !== want.value_class ||
              got.sign_out !== want.sign_out || got.binary32_bits !== want.binary32_bits ||
              m_axis_tdata[39:33] !== 7'd0 || m_axis_tuser[7:3] !== 5'd0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %b %0d %b %h, got %b %0d %b %h",
                       want.compatible, want.value_class, want.sign_out, want.binary32_bits,
                       got.compatible, got.value_class, got.sign_out, got.binary32_bits);
          end
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- dv/minifloat_decode_to_binary32_tb.sv -----
// Testbench top for the minifloat to binary32 decoder: drives formats and code words
// under several idling phases and reports the verdict. Uses mfd_pkg and the checker.
`default_nettype none
module minifloat_decode_to_binary32_tb;
  import mfd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  int          fail_count, pending;
  int          send_idle_pct, recv_stall_pct;
  int unsigned cur_frac = 10, cur_exp = 5;
  longint      cycle_count = 0;

  minifloat_decode_to_binary32 dut (.*);
  minifloat_decode_to_binary32_checker checker_u (.*, .fail_count_o(fail_count),
                                                  .pending_o(pending));

  initial forever #10 clk_i = ~clk_i;

  // Stall the receiver at the phase rate
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("minifloat_decode_to_binary32 regression: fail");
      $finish;
    end
  end

  // Hold valid until the transfer; drop it only while idling
  task automatic send_code(logic [31:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drain, then write one register
  task automatic write_reg(logic [3:0] idx, logic [3:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAC) cur_frac = val < 2 ? 2 : (val > 10 ? 10 : val);
    if (idx == REG_EXP) cur_exp = val[2:0] < 3 ? 3 : (val[2:0] > 5 ? 5 : val[2:0]);
  endtask

  // Mostly in-format codes with a few stray high bits
  function automatic logic [31:0] rand_code();
    int unsigned w;
    logic [31:0] c;
    w = cur_frac + cur_exp + 1;
    c = $urandom();
    case ($urandom_range(9))
      0: return c;
      1: return (c & ((32'd1 << w) - 1)) | (32'd1 << $urandom_range(31, w));
      2: return (c & ((32'd1 << cur_frac) - 1)) | (32'(c[31]) << (w - 1));
      3: return (c & ((32'd1 << cur_frac) - 1)) | (((32'd1 << cur_exp) - 1) << cur_frac) |
                (32'(c[31]) << (w - 1));
      default: return c & ((32'd1 << w) - 1);
    endcase
  endfunction

  task automatic directed_set();
    int unsigned n, k;
    logic [31:0] emax;
    n = cur_frac;
    k = cur_exp;
    emax = ((32'd1 << k) - 1) << n;
    send_code(0);
    send_code(32'd1 << (n + k));
    send_code(1);
    send_code((32'd1 << n) - 1);
    send_code(32'd1 << n);
    send_code(emax - (32'd1 << n) + (32'd1 << n) - 1 - (32'd1 << n) + (32'd1 << n));
    send_code(emax);
    send_code(emax | (32'd1 << (n + k)));
    send_code(emax | 1);
    send_code(emax | ((32'd1 << n) - 1) | (32'd1 << (n + k)));
    send_code(32'd1 << (n + k + 1));
    send_code(32'hFFFF_FFFF);
  endtask

  initial begin
    logic [3:0] fmts[8][2] = '{'{4'd10, 4'd5}, '{4'd2, 4'd3}, '{4'd0, 4'd0},
                               '{4'd15, 4'd7}, '{4'd6, 4'd4}, '{4'd3, 4'd5},
                               '{4'd10, 4'd3}, '{4'd7, 4'd4}};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_set();
    for (int f = 0; f < 8; f++) begin
      write_reg(REG_FRAC, fmts[f][0]);
      write_reg(REG_EXP, fmts[f][1]);
      write_reg(4'd9, 4'd5);
      directed_set();
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 19) : 0;
        recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 72 : 19) : 0;
        repeat (52) send_code(rand_code());
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("minifloat_decode_to_binary32 regression: pass");
    else $display("minifloat_decode_to_binary32 regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/mfd_pkg.sv
src/mfd_cfg.sv
src/mfd_core.sv
src/minifloat_decode_to_binary32.sv
dv/minifloat_decode_to_binary32_checker.sv
dv/minifloat_decode_to_binary32_tb.sv
